### design/tnfp_pkg.sv
// Package with shared types, constants and byte classifiers for the tar numeric field parser.
`timescale 1ns / 1ps

package tnfp_pkg;

    localparam int LEN_W               = 5;
    localparam int DEF_MAX_FIELD_BYTES = 16;
    localparam int VAL_W               = 64;

    // Queue between the front and the back; the depth is a power of two.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [7:0]       BYTE_ALL_ONES = 8'hFF;
    localparam logic [VAL_W-1:0] VAL_ALL_ONES  = {VAL_W{1'b1}};

    // One classified byte as it travels from the front to the back.
    typedef struct packed {
        logic [7:0]       data;
        logic             first;
        logic [LEN_W-1:0] len;
        logic             blank;
        logic             digit;
        logic [2:0]       digit_val;
        logic             all_ones;
    } t_cls;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    typedef enum logic [2:0] {
        PH_SKIP   = 3'b001,
        PH_DIGITS = 3'b010,
        PH_DONE   = 3'b100
    } t_phase;

    function automatic logic is_blank(input logic [7:0] b);
        return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
    endfunction

    function automatic logic is_oct_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h37);
    endfunction

endpackage

### design/tnfp_if.sv
// Valid/ready channel interfaces for the field bytes and the parsed results.
`timescale 1ns / 1ps

interface tnfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;
    logic [4:0] field_length;

    modport source (output valid, output data_byte, output first_byte,
                    output field_length, input ready);
    modport sink   (input valid, input data_byte, input first_byte,
                    input field_length, output ready);
endinterface

interface tnfp_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;
    logic        overflow_error;
    logic        used_base256;

    modport source (output valid, output value, output overflow_error,
                    output used_base256, input ready);
    modport sink   (input valid, input value, input overflow_error,
                    input used_base256, output ready);
endinterface

### design/tnfp_front.sv
// Front end: accepts field bytes and classifies each one for the back end.
`timescale 1ns / 1ps

module tnfp_front
    import tnfp_pkg::*;
#(
    parameter int MAX_FIELD_BYTES = DEF_MAX_FIELD_BYTES
) (
    tnfp_in_if.sink    i_in,
    input  logic       i_q_ready,
    output logic       o_push,
    output t_cls       o_cls
);

    logic [LEN_W-1:0] len_sat;

    always_comb begin
        if (int'(i_in.field_length) > MAX_FIELD_BYTES) begin
            len_sat = LEN_W'(MAX_FIELD_BYTES);
        end else begin
            len_sat = i_in.field_length;
        end
    end

    assign i_in.ready = i_q_ready;
    assign o_push     = i_in.valid && i_q_ready;

    assign o_cls.data      = i_in.data_byte;
    assign o_cls.first     = i_in.first_byte;
    assign o_cls.len       = len_sat;
    assign o_cls.blank     = is_blank(i_in.data_byte);
    assign o_cls.digit     = is_oct_digit(i_in.data_byte);
    assign o_cls.digit_val = i_in.data_byte[2:0];
    assign o_cls.all_ones  = (i_in.data_byte == BYTE_ALL_ONES);

endmodule

### design/tnfp_queue.sv
// Short FIFO of classified beats between the front and the back end.
`timescale 1ns / 1ps

module tnfp_queue
    import tnfp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cls    i_cls,
    output logic    o_ready,
    output logic    o_valid,
    output t_cls    o_cls,
    input  logic    i_pop,
    output t_q_stat o_stat
);

    t_cls               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_W-1:0] r_count, n_count;
    logic               push_ok, pop_ok;

    assign push_ok = i_push && (r_count != Q_CNT_W'(Q_DEPTH));
    assign pop_ok  = i_pop && (r_count != '0);

    always_comb begin
        n_wr_ptr = push_ok ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = pop_ok ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (push_ok && !pop_ok) begin
            n_count = r_count + 1'b1;
        end else if (pop_ok && !push_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_cls;
        end
    end

    assign o_ready     = (r_count != Q_CNT_W'(Q_DEPTH));
    assign o_valid     = (r_count != '0);
    assign o_cls       = r_mem[r_rd_ptr];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == Q_CNT_W'(Q_DEPTH));

endmodule

### design/tnfp_back.sv
// Back end: per-field parse state, octal and base-256 accumulation, result register.
`timescale 1ns / 1ps

module tnfp_back
    import tnfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_cls        i_cls,
    output logic        o_pop,
    tnfp_out_if.source  o_out
);

    logic [VAL_W-1:0] r_acc, n_acc;
    logic [LEN_W-1:0] r_left, n_left;
    logic             r_bin, n_bin;
    t_phase           r_phase, n_phase;
    logic             r_err, n_err;

    logic             r_out_valid;
    logic [VAL_W-1:0] r_value;
    logic             r_ovf;
    logic             r_b256;

    logic             pop;
    logic             active;
    logic             emit;
    logic             stop;
    logic [7:0]       x;
    logic [VAL_W-1:0] a;

    assign o_pop = !r_out_valid || o_out.ready;
    assign pop   = i_valid && o_pop;

    always_comb begin
        n_acc   = r_acc;
        n_left  = r_left;
        n_bin   = r_bin;
        n_phase = r_phase;
        n_err   = r_err;
        active  = 1'b0;
        emit    = 1'b0;
        stop    = 1'b0;
        x       = i_cls.data;
        a       = r_acc;

        if (pop) begin
            if (i_cls.first) begin
                n_left  = i_cls.len;
                n_acc   = '0;
                n_bin   = i_cls.data[7];
                n_phase = PH_SKIP;
                n_err   = 1'b0;
                if (i_cls.len == '0) begin
                    emit = 1'b1;
                end else begin
                    active = 1'b1;
                end
            end else if (r_left != '0) begin
                active = 1'b1;
            end
        end

        if (active) begin
            n_left = n_left - 1'b1;
            if (!n_err) begin
                if (n_bin) begin
                    a = n_acc;
                    if (i_cls.first) begin
                        if (i_cls.all_ones) begin
                            a = VAL_ALL_ONES;
                        end else begin
                            x = {1'b0, i_cls.data[6:0]};
                            a = '0;
                            // Fields longer than eight bytes may only carry sign padding.
                            if ((n_left > LEN_W'(7)) && (x != 8'h00)) begin
                                n_err = 1'b1;
                                stop  = 1'b1;
                            end
                        end
                    end
                    if (!stop) begin
                        if ((a[63:56] != 8'h00) && (a[63:56] != BYTE_ALL_ONES)) begin
                            n_err = 1'b1;
                        end else begin
                            n_acc = {a[55:0], x};
                        end
                    end
                end else begin
                    unique case (n_phase)
                        PH_SKIP, PH_DIGITS: begin
                            if ((n_phase == PH_SKIP) && i_cls.blank) begin
                                n_phase = PH_SKIP;
                            end else if (!i_cls.digit) begin
                                n_phase = PH_DONE;
                            end else if (n_acc[63:61] != 3'b000) begin
                                n_err   = 1'b1;
                                n_phase = PH_DONE;
                            end else begin
                                n_acc   = {n_acc[60:0], i_cls.digit_val};
                                n_phase = PH_DIGITS;
                            end
                        end
                        PH_DONE: begin
                            n_phase = PH_DONE;
                        end
                        default: begin
                            n_phase = PH_DONE;
                        end
                    endcase
                end
            end
            if (n_left == '0) begin
                emit = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_left      <= '0;
            r_bin       <= 1'b0;
            r_phase     <= PH_SKIP;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_acc   <= n_acc;
            r_left  <= n_left;
            r_bin   <= n_bin;
            r_phase <= n_phase;
            r_err   <= n_err;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_value <= n_err ? '0 : n_acc;
            r_ovf   <= n_err;
            r_b256  <= n_bin;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.value          = r_value;
    assign o_out.overflow_error = r_ovf;
    assign o_out.used_base256   = r_b256;

endmodule

### design/tar_numeric_field_parser_core.sv
// Top level of the tar header numeric field parser: front end, queue and back end.
//
// Usage: the bytes of one tar header numeric field arrive on i_in, one byte per beat, with
// first_byte set on the field's first byte, which also carries field_length (values above
// MAX_FIELD_BYTES are clamped). A first byte with bit 7 set selects base-256 big-endian
// decoding; otherwise the field is parsed as octal after leading whitespace. One result
// beat per field leaves on o_out after the field's last byte is processed; it carries the value,
// an overflow flag (value forced to zero) and the base-256 indication. A field of length
// zero gives its result from the first byte alone. Stray bytes outside a field are dropped,
// and a new first byte abandons any open field without a result.
// Timing: one input beat per cycle sustained while the queue has room. A result reaches o_out
// after the field's last byte is accepted: the byte is written into the queue, then the back-end
// update (a 64-bit shift and OR plus small compares) loads the output register.
// Stalls: the result sits in an output register; while o_out is stalled, the back end
// pauses and the front end keeps filling a four-beat queue, then drops i_in.ready.
// Reset: a synchronous active-low reset empties the queue, closes any open field and
// clears the output valid.

`timescale 1ns / 1ps

module tar_numeric_field_parser_core
    import tnfp_pkg::*;
#(
    parameter int MAX_FIELD_BYTES = DEF_MAX_FIELD_BYTES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tnfp_in_if.sink    i_in,
    tnfp_out_if.source o_out
);

    logic    push;
    logic    q_ready;
    t_cls    push_cls;
    logic    q_valid;
    t_cls    q_cls;
    logic    pop_ready;
    t_q_stat q_stat;

    // Classifies each accepted byte and pushes it into the queue.
    tnfp_front #(
        .MAX_FIELD_BYTES (MAX_FIELD_BYTES)
    ) u_front (
        .i_in      (i_in),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_cls     (push_cls)
    );

    // Decouples the front end from stalls of the result channel.
    tnfp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cls   (push_cls),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_cls   (q_cls),
        .i_pop   (pop_ready),
        .o_stat  (q_stat)
    );

    // Holds the per-field state and produces the result beat.
    tnfp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_cls   (q_cls),
        .o_pop   (pop_ready),
        .o_out   (o_out)
    );

`ifndef ASSERT_OFF
    // An overflowed field always reports a zero value.
    a_ovf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.overflow_error) |-> (o_out.value == '0))
        else $error("overflow result with nonzero value");

    // A beat pushed without a pop leaves the queue non-empty.
    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !(q_valid && pop_ready)) |=> !q_stat.empty)
        else $error("queue empty after push without pop");

    // A beat popped without a push leaves room in the queue.
    a_pop_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_valid && pop_ready && !push) |=> !q_stat.full)
        else $error("queue full after pop without push");

    // The front end never takes a byte while the queue is full.
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.full |-> !i_in.ready)
        else $error("input ready while queue full");
`endif

endmodule
